@@ hw/rtl/xild_pkg.sv @@
package xild_pkg;

    localparam int WIN_BYTES  = 15;
    localparam int WIN_W      = 8 * WIN_BYTES;
    localparam int HEAD_BYTES = 5;
    localparam int HEAD_W     = 8 * HEAD_BYTES;
    localparam int POS_W      = 4;
    localparam int SUM_W      = 5;
    localparam int LEN_W      = 4;
    localparam int OUT_W      = 8;

    localparam logic [7:0] PFX_OSZ   = 8'h66;
    localparam logic [7:0] PFX_ASZ   = 8'h67;
    localparam logic [7:0] OP_ESC    = 8'h0F;
    localparam logic [7:0] ESC_38    = 8'h38;
    localparam logic [7:0] ESC_3A    = 8'h3A;
    localparam logic [7:0] OP_TEST_B = 8'hF6;
    localparam logic [7:0] OP_TEST_V = 8'hF7;
    localparam logic [7:0] OP_MOV_IV = 8'hC7;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic       reject;
        logic [1:0] op_len;
        logic       need_mrm;
        logic [2:0] imm_len;
        logic       test_b;
        logic       test_v;
    } op_dec_t;

    function automatic logic is_prefix(byte_t b);
        return b == PFX_OSZ || b == PFX_ASZ || b == 8'hF0 || b == 8'hF2 ||
               b == 8'hF3 || b == 8'h26 || b == 8'h2E || b == 8'h36 ||
               b == 8'h3E || b == 8'h64 || b == 8'h65;
    endfunction

    function automatic op_dec_t op_decode(byte_t b0, byte_t b1, logic osz, logic asz);
        op_dec_t    d;
        logic [2:0] zimm;
        logic       bare;
        d      = '0;
        zimm   = osz ? 3'd2 : 3'd4;
        bare   = 1'b0;
        d.op_len = 2'd1;
        if (b0 == OP_ESC) begin
            d.op_len = 2'd2;
            bare = (b1 >= 8'h05 && b1 <= 8'h09) || b1 == 8'h0B ||
                   (b1 >= 8'h30 && b1 <= 8'h35) || b1 == 8'h37 ||
                   b1 == 8'h77 || (b1 >= 8'hA0 && b1 <= 8'hA2) ||
                   b1 == 8'hA8 || b1 == 8'hA9 || (b1 >= 8'hC8 && b1 <= 8'hCF);
            if (b1[7:4] == 4'h8) begin
                d.reject = 1'b1;
            end else if (b1 == ESC_38 || b1 == ESC_3A) begin
                d.op_len   = 2'd3;
                d.need_mrm = 1'b1;
                d.imm_len  = (b1 == ESC_3A) ? 3'd1 : 3'd0;
            end else if (!bare) begin
                d.need_mrm = 1'b1;
                if ((b1 >= 8'h70 && b1 <= 8'h73) || b1 == 8'hA4 || b1 == 8'hAC ||
                    b1 == 8'hBA || b1 == 8'hC2 || (b1 >= 8'hC4 && b1 <= 8'hC6)) begin
                    d.imm_len = 3'd1;
                end
            end
        end else if ((b0 >= 8'h70 && b0 <= 8'h7F) || (b0 >= 8'hE0 && b0 <= 8'hE9) ||
                     b0 == 8'hEB || b0 == 8'h9A || b0 == 8'hEA) begin
            d.reject = 1'b1;
        end else if (b0 < 8'h40 && b0[2:0] == 3'd4) begin
            d.imm_len = 3'd1;
        end else if (b0 < 8'h40 && b0[2:0] == 3'd5) begin
            d.imm_len = zimm;
        end else if (b0 >= 8'hB0 && b0 <= 8'hB7) begin
            d.imm_len = 3'd1;
        end else if ((b0 >= 8'hB8) && (b0 <= 8'hBF)) begin
            d.imm_len = zimm;
        end else if ((b0 < 8'h40 && !b0[2]) || b0 == 8'h62 || b0 == 8'h63 ||
                     (b0 >= 8'h84 && b0 <= 8'h8F) || b0 == 8'hC4 || b0 == 8'hC5 ||
                     (b0 >= 8'hD0 && b0 <= 8'hD3) || b0 == 8'hFE || b0 == 8'hFF ||
                     b0 == OP_TEST_B || b0 == OP_TEST_V) begin
            d.need_mrm = 1'b1;
            d.test_b   = (b0 == OP_TEST_B);
            d.test_v   = (b0 == OP_TEST_V);
        end else if (b0 == 8'h69 || b0 == 8'h81 || b0 == OP_MOV_IV) begin
            d.need_mrm = 1'b1;
            d.imm_len  = zimm;
        end else if (b0 == 8'h6B || b0 == 8'h80 || b0 == 8'h82 || b0 == 8'h83 ||
                     b0 == 8'hC0 || b0 == 8'hC1 || b0 == 8'hC6) begin
            d.need_mrm = 1'b1;
            d.imm_len  = 3'd1;
        end else if (b0 == 8'h68 || b0 == 8'hA9) begin
            d.imm_len = zimm;
        end else if (b0 == 8'h6A || b0 == 8'hA8 || b0 == 8'hCD || b0 == 8'hD4 ||
                     b0 == 8'hD5) begin
            d.imm_len = 3'd1;
        end else if (b0 >= 8'hA0 && b0 <= 8'hA3) begin
            d.imm_len = asz ? 3'd2 : 3'd4;
        end else if (b0 == 8'hC2 || b0 == 8'hCA) begin
            d.imm_len = 3'd2;
        end else if (b0 == 8'hC8) begin
            d.imm_len = 3'd3;
        end else if (!((b0 >= 8'h40 && b0 <= 8'h5F) || (b0 >= 8'h90 && b0 <= 8'h9F) ||
                       (b0 >= 8'hA4 && b0 <= 8'hA7) || (b0 >= 8'hAA && b0 <= 8'hAF) ||
                       b0 == 8'hC3 || (b0 >= 8'hCC && b0 <= 8'hCF) ||
                       b0 == 8'hD6 || b0 == 8'hD7 || (b0 >= 8'hEC && b0 <= 8'hEF) ||
                       (b0 >= 8'hF4 && b0 <= 8'hFD))) begin
            d.reject = 1'b1;
        end
        return d;
    endfunction

endpackage

@@ hw/rtl/x86_instruction_length_decoder.sv @@
// Pipeline from input transfer to result on m_tvalid: prefix scan, opcode
// align, opcode decode, ModRM/SIB and length sum, one register each.
// Throughput: one window per cycle; stages with no valid item fill in, so a
// stalled output only holds the stages behind it once they are all full.
// Reset: aresetn synchronous active low clears the stage valid bits only.
module x86_instruction_length_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [119:0] s_tdata,   // [63:0] window_low, [119:64] window_high
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata     // [0] accepted, [4:1] length, [7:5] zero
);

    // stage handshake
    logic ready1, ready2, ready3, ready4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    assign ready4   = !v4_reg || m_tready;
    assign ready3   = !v3_reg || ready4;
    assign ready2   = !v2_reg || ready3;
    assign ready1   = !v1_reg || ready2;
    assign s_tready = ready1;
    assign m_tvalid = v4_reg;

    // stage 1: prefix scan
    logic [xild_pkg::POS_W-1:0] pos1_next, pos1_reg;
    logic                       osz1_next, asz1_next, osz1_reg, asz1_reg;
    logic [xild_pkg::WIN_W-1:0] win1_reg;

    always_comb begin
        logic run;
        pos1_next = xild_pkg::POS_W'(xild_pkg::WIN_BYTES);
        for (int i = xild_pkg::WIN_BYTES - 1; i >= 0; i--) begin
            if (!xild_pkg::is_prefix(s_tdata[8*i +: 8])) begin
                pos1_next = xild_pkg::POS_W'(i);
            end
        end
        run       = 1'b1;
        osz1_next = 1'b0;
        asz1_next = 1'b0;
        for (int i = 0; i < xild_pkg::WIN_BYTES; i++) begin
            if (run && s_tdata[8*i +: 8] == xild_pkg::PFX_OSZ) osz1_next = 1'b1;
            if (run && s_tdata[8*i +: 8] == xild_pkg::PFX_ASZ) asz1_next = 1'b1;
            run = run && xild_pkg::is_prefix(s_tdata[8*i +: 8]);
        end
    end

    // stage 2: align window on the opcode
    logic [xild_pkg::WIN_W-1:0]  shift2;
    logic [xild_pkg::HEAD_W-1:0] hd2_reg;
    logic [xild_pkg::POS_W-1:0]  pos2_reg;
    logic                        osz2_reg, asz2_reg;

    assign shift2 = win1_reg >> {pos1_reg, 3'b000};

    // stage 3: opcode decode
    xild_pkg::op_dec_t          dec3;
    logic [xild_pkg::SUM_W-1:0] base3_next, base3_reg;
    logic                       rej3_next, rej3_reg;
    xild_pkg::byte_t            mrm3_next, sib3_next, mrm3_reg, sib3_reg;
    logic                       need_mrm3_reg, test_b3_reg, test_v3_reg;
    logic [2:0]                 imm3_reg;
    logic                       osz3_reg, asz3_reg;

    always_comb begin
        dec3       = xild_pkg::op_decode(hd2_reg[7:0], hd2_reg[15:8], osz2_reg, asz2_reg);
        base3_next = {1'b0, pos2_reg} + xild_pkg::SUM_W'(dec3.op_len);
        rej3_next  = dec3.reject || (base3_next > xild_pkg::SUM_W'(xild_pkg::WIN_BYTES));
        unique case (dec3.op_len)
            2'd1: begin
                mrm3_next = hd2_reg[15:8];
                sib3_next = hd2_reg[23:16];
            end
            2'd2: begin
                mrm3_next = hd2_reg[23:16];
                sib3_next = hd2_reg[31:24];
            end
            2'd3: begin
                mrm3_next = hd2_reg[31:24];
                sib3_next = hd2_reg[39:32];
            end
            default: begin
                mrm3_next = '0;
                sib3_next = '0;
            end
        endcase
    end

    // stage 4: ModRM, SIB, displacement and length sum
    logic [1:0]                 md4;
    logic [2:0]                 rg4, rm4;
    logic [xild_pkg::SUM_W-1:0] imm4, mrm_n4, sib_n4, disp4, total4;
    logic                       rej4;
    logic                       acc4_next, acc4_reg;
    logic [xild_pkg::LEN_W-1:0] len4_next, len4_reg;

    always_comb begin
        md4    = mrm3_reg[7:6];
        rg4    = mrm3_reg[5:3];
        rm4    = mrm3_reg[2:0];
        imm4   = xild_pkg::SUM_W'(imm3_reg);
        mrm_n4 = '0;
        sib_n4 = '0;
        disp4  = '0;
        rej4   = rej3_reg;
        if (need_mrm3_reg) begin
            if (base3_reg >= xild_pkg::SUM_W'(xild_pkg::WIN_BYTES)) rej4 = 1'b1;
            mrm_n4 = xild_pkg::SUM_W'(1);
            if (test_b3_reg && rg4 <= 3'd1) begin
                imm4 = xild_pkg::SUM_W'(1);
            end else if (test_v3_reg && rg4 <= 3'd1) begin
                imm4 = osz3_reg ? xild_pkg::SUM_W'(2) : xild_pkg::SUM_W'(4);
            end
            if (md4 != 2'd3) begin
                if (asz3_reg) begin
                    if ((md4 == 2'd0 && rm4 == 3'd6) || md4 == 2'd2) begin
                        disp4 = xild_pkg::SUM_W'(2);
                    end else if (md4 == 2'd1) begin
                        disp4 = xild_pkg::SUM_W'(1);
                    end
                end else begin
                    if (rm4 == 3'd4) begin
                        if (base3_reg >= xild_pkg::SUM_W'(xild_pkg::WIN_BYTES - 1)) begin
                            rej4 = 1'b1;
                        end
                        sib_n4 = xild_pkg::SUM_W'(1);
                        if (md4 == 2'd0 && sib3_reg[2:0] == 3'd5) begin
                            disp4 = xild_pkg::SUM_W'(4);
                        end
                    end
                    if ((md4 == 2'd0 && rm4 == 3'd5) || md4 == 2'd2) begin
                        disp4 = xild_pkg::SUM_W'(4);
                    end else if (md4 == 2'd1) begin
                        disp4 = xild_pkg::SUM_W'(1);
                    end
                end
            end
        end
        total4 = base3_reg + mrm_n4 + sib_n4 + disp4 + imm4;
        if (total4 > xild_pkg::SUM_W'(xild_pkg::WIN_BYTES)) rej4 = 1'b1;
        acc4_next = !rej4;
        len4_next = rej4 ? '0 : total4[xild_pkg::LEN_W-1:0];
    end

    assign m_tdata = {3'b000, len4_reg, acc4_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (ready1) v1_reg <= s_tvalid;
            if (ready2) v2_reg <= v1_reg;
            if (ready3) v3_reg <= v2_reg;
            if (ready4) v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ready1) begin
            win1_reg <= s_tdata;
            pos1_reg <= pos1_next;
            osz1_reg <= osz1_next;
            asz1_reg <= asz1_next;
        end
        if (ready2) begin
            hd2_reg  <= shift2[xild_pkg::HEAD_W-1:0];
            pos2_reg <= pos1_reg;
            osz2_reg <= osz1_reg;
            asz2_reg <= asz1_reg;
        end
        if (ready3) begin
            base3_reg     <= base3_next;
            rej3_reg      <= rej3_next;
            mrm3_reg      <= mrm3_next;
            sib3_reg      <= sib3_next;
            need_mrm3_reg <= dec3.need_mrm;
            imm3_reg      <= dec3.imm_len;
            test_b3_reg   <= dec3.test_b;
            test_v3_reg   <= dec3.test_v;
            osz3_reg      <= osz2_reg;
            asz3_reg      <= asz2_reg;
        end
        if (ready4) begin
            acc4_reg <= acc4_next;
            len4_reg <= len4_next;
        end
    end

endmodule

@@ hw/rtl/xild_checker.sv @@
module xild_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    a_acc_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[4:1] != 4'd0)) && (m_tdata[7:5] == 3'd0))
        else $error("accepted flag disagrees with length");

    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output is free");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(s_tvalid && s_tready, 4) && $past(aresetn, 4) && $past(aresetn, 3) &&
        $past(aresetn, 2) && $past(aresetn, 1) && $past(m_tready, 3) &&
        $past(m_tready, 2) && $past(m_tready, 1) |-> m_tvalid)
        else $error("result missing four cycles after transfer");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind x86_instruction_length_decoder xild_checker u_xild_checker (.*);
